### src/ipe_pkg.sv
// Shared widths, operator codes and parameter defaults for the infix
// precedence evaluator. No dependencies.
`timescale 1ns / 1ps

package ipe_pkg;

  localparam int OPERAND_W = 32;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 2;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

endpackage

### src/infix_precedence_evaluator_top.sv
// Infix expression evaluator with multiply/divide precedence, fixed point.
// Depends on ipe_pkg.
`timescale 1ns / 1ps

// Streams a flat infix expression one operand word at a time; each word
// carries the operator that joins it to the previous operand, and the word
// flagged last closes the expression and yields one result word (value plus
// divide-by-zero and overflow flags), after which the block starts fresh.
// Per operand word: the first operand and add/subtract are taken in the
// idle state itself, so they stream back to back. Multiply runs a shift-add
// over the multiplier bits, one bit per cycle, then a rounding state and a
// sign-and-saturate state. Divide runs a restoring divider, one quotient
// bit per cycle over WORD_BITS + FRAC_BITS numerator bits, then the
// sign-and-saturate state; a zero divisor skips the divider. The last word
// adds a commit state for the final add and output clamp, and waits there
// only if the previous result word is still unclaimed. The result register
// lets the next expression start while a result waits downstream.
module infix_precedence_evaluator_top #(
  parameter int WORD_BITS = ipe_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = ipe_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // operand channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic signed [ipe_pkg::OPERAND_W-1:0] operand,
  input  ipe_pkg::op_t                         op_before,
  input  logic                                 last,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [ipe_pkg::VALUE_W-1:0]   value,
  output logic                                 divide_by_zero,
  output logic                                 overflowed
);
  import ipe_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int PROD_W = 2 * W;
  localparam int NUM_W  = W + FRAC_BITS;
  localparam int MAG_W  = (PROD_W > NUM_W) ? PROD_W : NUM_W;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int EXT_W  = (W > OPERAND_W) ? W : OPERAND_W;
  localparam int FIN_W  = (W + 1 > VALUE_W + 1) ? W + 1 : VALUE_W + 1;
  localparam int CLAMP_W = (W < VALUE_W) ? W : VALUE_W;
  localparam bit RND_EN  = (FRAC_BITS > 0);
  localparam int RND_IDX = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic signed [EXT_W-1:0] X_HI = EXT_W'(WMAX);
  localparam logic signed [EXT_W-1:0] X_LO = ~X_HI;

  localparam logic signed [FIN_W-1:0] F_HI =
    FIN_W'((64'sd1 <<< (CLAMP_W - 1)) - 64'sd1);
  localparam logic signed [FIN_W-1:0] F_LO = ~F_HI;

  localparam logic [MAG_W-1:0] HALF    = MAG_W'(1) << (W - 1);
  localparam logic [MAG_W-1:0] LIM_POS = HALF - MAG_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take operand words
  localparam logic [2:0] S_MUL  = 3'd1;  // one multiplier bit per cycle
  localparam logic [2:0] S_MRND = 3'd2;  // drop fraction, round half away
  localparam logic [2:0] S_DIV  = 3'd3;  // one quotient bit per cycle
  localparam logic [2:0] S_SAT  = 3'd4;  // sign and saturate the term
  localparam logic [2:0] S_END  = 3'd5;  // final commit, load result

  // expression state
  logic [2:0]          state;
  logic signed [W-1:0] sum;
  logic signed [W-1:0] product;
  logic                term_neg;
  logic                first;
  logic                flag_div0;
  logic                flag_ovf;
  logic                last_r;

  // arithmetic datapath
  logic                res_neg;
  logic [W-1:0]        ma;
  logic [W-1:0]        mb;
  logic [PROD_W-1:0]   pacc;
  logic [NUM_W-1:0]    qn;
  logic [W-1:0]        rem;
  logic [MAG_W-1:0]    mag;
  logic [CNT_W-1:0]    cnt;

  logic item_acc;
  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;

  // operand clamp to the word
  logic signed [EXT_W-1:0] x_ext;
  logic signed [W-1:0]     x_sat;
  logic                    x_ovf;
  logic [W-1:0]            x_mag;
  logic [W-1:0]            p_mag;

  always_comb begin
    x_ext = EXT_W'(operand);
    x_ovf = 1'b0;
    if (x_ext > X_HI) begin
      x_sat = WMAX;
      x_ovf = 1'b1;
    end else if (x_ext < X_LO) begin
      x_sat = WMIN;
      x_ovf = 1'b1;
    end else begin
      x_sat = x_ext[W-1:0];
    end
    x_mag = x_sat[W-1] ? (~x_sat + 1'b1) : x_sat;
    p_mag = product[W-1] ? (~product + 1'b1) : product;
  end

  // commit of the pending term into the sum
  logic signed [W:0]   c_sum;
  logic                c_ovf;
  logic signed [W-1:0] c_sat;

  always_comb begin
    if (term_neg) begin
      c_sum = {sum[W-1], sum} - {product[W-1], product};
    end else begin
      c_sum = {sum[W-1], sum} + {product[W-1], product};
    end
    c_ovf = (c_sum[W] != c_sum[W-1]);
    if (c_ovf) begin
      c_sat = c_sum[W] ? WMIN : WMAX;
    end else begin
      c_sat = c_sum[W-1:0];
    end
  end

  // final clamp: to the narrower of the word range and the output range
  logic signed [FIN_W-1:0]   f_ext;
  logic                      f_ovf;
  logic [VALUE_W-1:0]        f_val;

  always_comb begin
    f_ext = FIN_W'(c_sum);
    f_ovf = 1'b0;
    if (f_ext > F_HI) begin
      f_val = F_HI[VALUE_W-1:0];
      f_ovf = 1'b1;
    end else if (f_ext < F_LO) begin
      f_val = F_LO[VALUE_W-1:0];
      f_ovf = 1'b1;
    end else begin
      f_val = f_ext[VALUE_W-1:0];
    end
  end

  // multiply step: add multiplicand into top half, shift right
  logic [W:0]        m_sum;
  logic [PROD_W-1:0] pacc_next;
  logic [PROD_W-1:0] p_sh;
  logic              rnd;

  always_comb begin
    m_sum     = {1'b0, pacc[PROD_W-1:W]} + (mb[0] ? {1'b0, ma} : '0);
    pacc_next = {m_sum, pacc[W-1:1]};
    p_sh      = pacc >> RND_IDX;
    rnd       = RND_EN && p_sh[0];
  end

  // divide step: restoring, numerator shifts out of qn as quotient enters
  logic [W:0]       r_sh;
  logic [W:0]       r_sub;
  logic             d_ge;
  logic [NUM_W-1:0] qn_next;

  always_comb begin
    r_sh    = {rem, qn[NUM_W-1]};
    r_sub   = r_sh - {1'b0, mb};
    d_ge    = (r_sh >= {1'b0, mb});
    qn_next = {qn[NUM_W-2:0], d_ge};
  end

  // sign and saturate a finished magnitude
  logic                s_over;
  logic [W-1:0]        s_low;
  logic signed [W-1:0] s_val;

  always_comb begin
    s_low  = mag[W-1:0];
    s_over = (mag > LIM_POS) && !(res_neg && (mag == HALF));
    if (s_over) begin
      s_val = res_neg ? WMIN : WMAX;
    end else begin
      s_val = res_neg ? (~s_low + 1'b1) : s_low;
    end
  end

  logic out_free;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sum          <= '0;
      product      <= '0;
      term_neg     <= 1'b0;
      first        <= 1'b1;
      flag_div0    <= 1'b0;
      flag_ovf     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // the commit state reloads the result itself
      if (result_valid && !result_stall && (state != S_END)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_acc) begin
            last_r <= last;
            if (x_ovf) begin
              flag_ovf <= 1'b1;
            end
            if (first) begin
              sum      <= '0;
              product  <= x_sat;
              term_neg <= 1'b0;
              first    <= 1'b0;
              state    <= last ? S_END : S_IDLE;
            end else begin
              case (op_before)
                OP_MUL: begin
                  ma      <= p_mag;
                  mb      <= x_mag;
                  res_neg <= product[W-1] ^ x_sat[W-1];
                  pacc    <= '0;
                  cnt     <= CNT_W'(W - 1);
                  state   <= S_MUL;
                end
                OP_DIV: begin
                  if (x_sat == '0) begin
                    flag_div0 <= 1'b1;
                    product   <= product[W-1] ? WMIN : WMAX;
                    state     <= last ? S_END : S_IDLE;
                  end else begin
                    mb      <= x_mag;
                    res_neg <= product[W-1] ^ x_sat[W-1];
                    qn      <= NUM_W'(p_mag) << FRAC_BITS;
                    rem     <= '0;
                    cnt     <= CNT_W'(NUM_W - 1);
                    state   <= S_DIV;
                  end
                end
                default: begin
                  // add or subtract closes the current term
                  sum      <= c_sat;
                  product  <= x_sat;
                  term_neg <= (op_before == OP_SUB);
                  if (c_ovf && !x_ovf) begin
                    flag_ovf <= 1'b1;
                  end
                  state <= last ? S_END : S_IDLE;
                end
              endcase
            end
          end
        end

        S_MUL: begin
          pacc <= pacc_next;
          mb   <= mb >> 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_MRND;
          end
        end

        S_MRND: begin
          mag   <= MAG_W'(pacc >> FRAC_BITS) + MAG_W'(rnd);
          state <= S_SAT;
        end

        S_DIV: begin
          rem <= d_ge ? r_sub[W-1:0] : r_sh[W-1:0];
          qn  <= qn_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            mag   <= MAG_W'(qn_next);
            state <= S_SAT;
          end
        end

        S_SAT: begin
          product <= s_val;
          if (s_over) begin
            flag_ovf <= 1'b1;
          end
          state <= last_r ? S_END : S_IDLE;
        end

        S_END: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            value          <= f_val;
            divide_by_zero <= flag_div0;
            overflowed     <= flag_ovf | f_ovf;
            // back to the reset state for the next expression
            sum       <= '0;
            product   <= '0;
            term_neg  <= 1'b0;
            first     <= 1'b1;
            flag_div0 <= 1'b0;
            flag_ovf  <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/ipe_checker.sv
// Port-level checks for the infix precedence evaluator, bound to its top.
// Depends on ipe_pkg and infix_precedence_evaluator_top.
`timescale 1ns / 1ps

module ipe_checker #(
  parameter int WORD_BITS = ipe_pkg::DEF_WORD_BITS
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_stall,
  input logic signed [ipe_pkg::OPERAND_W-1:0] operand,
  input logic                                 last,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [ipe_pkg::VALUE_W-1:0]   value,
  input logic                                 divide_by_zero,
  input logic                                 overflowed
);
  import ipe_pkg::*;

  localparam bit WIDE_WORD = (WORD_BITS >= OPERAND_W);

  logic item_acc;
  logic first_pend;

  assign item_acc = item_valid && !item_stall;

  // tracks whether the next word opens an expression
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pend <= 1'b1;
    end else if (item_acc) begin
      first_pend <= last;
    end
  end

  // closing word always leads into the commit state, which stalls operands
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    item_acc && last |=> item_stall)
    else $error("operand channel open right after a closing word");

  // results come only out of the commit state
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared while operands were being taken");

  // a lone operand passes through untouched
  a_lone_operand: assert property (@(posedge clk) disable iff (rst)
    WIDE_WORD && item_acc && first_pend && last && !result_valid |=> ##1
    (result_valid && value == $past(operand, 2) && !divide_by_zero && !overflowed))
    else $error("lone operand did not pass through");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
    result_valid && $stable(value) && $stable(divide_by_zero) && $stable(overflowed))
    else $error("stalled result word changed");

endmodule

bind infix_precedence_evaluator_top ipe_checker #(.WORD_BITS(WORD_BITS)) u_ipe_checker (.*);
